// ===== src/qstick_moving_average_assert.svh =====
// Assertion macros shared by the qstick moving average RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef QSTICK_MOVING_AVERAGE_ASSERT_SVH
`define QSTICK_MOVING_AVERAGE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define QSMA_ASSERT_ALW(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("qsma check failed");

// Consequent holds in the same cycle as the antecedent.
`define QSMA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qsma check failed");

// Consequent holds in the cycle after the antecedent.
`define QSMA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qsma check failed");

`endif

// ===== src/qsma_pkg.sv =====
`timescale 1ns / 1ps
// Package for the qstick moving average: widths, register codes, reset values
// and the window clamp function. No dependencies.
package qsma_pkg;

	localparam int MAX_WINDOW = 256;
	localparam int PRICE_BITS = 32;
	localparam int DIFF_BITS = PRICE_BITS + 1;
	localparam int OUT_BITS = PRICE_BITS + 1;
	localparam int LEN_BITS = 9;
	localparam int RECIP_BITS = 25;
	localparam int FRAC_BITS = 24;
	localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS = DIFF_BITS + $clog2(MAX_WINDOW);
	localparam int EXT_BITS = (SUM_BITS > FRAC_BITS) ? SUM_BITS : FRAC_BITS + 1;
	localparam int HI_BITS = EXT_BITS - FRAC_BITS;
	localparam int PROD_HI_BITS = HI_BITS + RECIP_BITS;
	localparam int RES_BITS = PROD_HI_BITS + 1;
	localparam int CFG_DATA_BITS = (RECIP_BITS > LEN_BITS) ? RECIP_BITS : LEN_BITS;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [LEN_BITS-1:0] RESET_WINDOW_LENGTH = 9'd14;
	localparam logic [RECIP_BITS-1:0] RESET_WINDOW_RECIPROCAL = 25'd1198373;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WINDOW_LENGTH,
		REG_WINDOW_RECIPROCAL
	} cfg_reg_t;

	typedef struct packed {
		logic shift;
		logic sel_load;
	} chain_ctrl_t;

	// A length of zero acts as one; lengths above the line depth act as the depth.
	function automatic logic [CNT_BITS-1:0] clamp_window(input logic [LEN_BITS-1:0] len);
		logic [CNT_BITS-1:0] w;
		if (len == '0) begin
			w = CNT_BITS'(1);
		end else if (int'(len) > MAX_WINDOW) begin
			w = CNT_BITS'(MAX_WINDOW);
		end else begin
			w = CNT_BITS'(len);
		end
		return w;
	endfunction

endpackage

// ===== src/qsma_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the price input and the mean output.
// Depends on qsma_pkg for the field widths.
interface qsma_in_if;
	logic valid;
	logic ready;
	logic signed [qsma_pkg::PRICE_BITS-1:0] open_price;
	logic signed [qsma_pkg::PRICE_BITS-1:0] close_price;
	logic start_new;

	modport source(output valid, output open_price, output close_price, output start_new,
		input ready);
	modport sink(input valid, input open_price, input close_price, input start_new,
		output ready);
endinterface

interface qsma_out_if;
	logic valid;
	logic ready;
	logic signed [qsma_pkg::OUT_BITS-1:0] mean_body;

	modport source(output valid, output mean_body, input ready);
	modport sink(input valid, input mean_body, output ready);
endinterface

// ===== src/qsma_cell.sv =====
`timescale 1ns / 1ps
// One cell of the difference delay line: holds one body difference, passes it
// to its neighbor on each shift and gates it onto the tap. Depends on qsma_pkg.
module qsma_cell (
	input  logic                             clk,
	input  logic                             shift,
	input  logic                             sel,
	input  logic [qsma_pkg::DIFF_BITS-1:0]   d,
	output logic [qsma_pkg::DIFF_BITS-1:0]   q,
	output logic [qsma_pkg::DIFF_BITS-1:0]   tap
);

	logic [qsma_pkg::DIFF_BITS-1:0] data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;
	assign tap = sel ? data_q : '0;

endmodule

// ===== src/qsma_delay_line.sv =====
`timescale 1ns / 1ps
// Row of qsma_cell instances holding the most recent body differences, newest
// first, with a one-hot tap at the window depth. Depends on qsma_pkg, qsma_cell.
`include "qstick_moving_average_assert.svh"

module qsma_delay_line (
	input  logic                             clk,
	input  logic                             arst_n,
	input  qsma_pkg::chain_ctrl_t            ctrl,
	input  logic [qsma_pkg::CNT_BITS-1:0]    win_load,
	input  logic [qsma_pkg::DIFF_BITS-1:0]   diff_in,
	output logic [qsma_pkg::DIFF_BITS-1:0]   tap
);

	logic [qsma_pkg::MAX_WINDOW-1:0] sel_q;
	logic [qsma_pkg::DIFF_BITS-1:0] din [qsma_pkg::MAX_WINDOW];
	logic [qsma_pkg::DIFF_BITS-1:0] link [qsma_pkg::MAX_WINDOW];
	logic [qsma_pkg::DIFF_BITS-1:0] taps [qsma_pkg::MAX_WINDOW];

	// The selected cell holds the difference that entered window-length beats ago.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < qsma_pkg::MAX_WINDOW; k++) begin
				sel_q[k] <= (k + 1 == int'(qsma_pkg::clamp_window(
					qsma_pkg::RESET_WINDOW_LENGTH)));
			end
		end else if (ctrl.sel_load) begin
			for (int k = 0; k < qsma_pkg::MAX_WINDOW; k++) begin
				sel_q[k] <= (k + 1 == int'(win_load));
			end
		end
	end

	for (genvar k = 0; k < qsma_pkg::MAX_WINDOW; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign din[k] = diff_in;
		end else begin : g_body
			assign din[k] = link[k-1];
		end

		qsma_cell u_cell (
			.clk   (clk),
			.shift (ctrl.shift),
			.sel   (sel_q[k]),
			.d     (din[k]),
			.q     (link[k]),
			.tap   (taps[k])
		);
	end

	always_comb begin
		tap = '0;
		for (int k = 0; k < qsma_pkg::MAX_WINDOW; k++) begin
			tap = tap | taps[k];
		end
	end

	`QSMA_ASSERT_ALW(a_tap_onehot, clk, arst_n, $onehot(sel_q))

endmodule

// ===== src/qstick_moving_average.sv =====
`timescale 1ns / 1ps
// Qstick windowed mean: four register stages; a result beat passes through s1, s2, s3 and
// s4 in order after the input beat that causes it is accepted, and is offered from s4.
// Throughput is one input beat per cycle while no stall holds s1, set by the running-sum update.
// Ready runs combinationally from the output back to the input, so inputs keep flowing
// into empty stages while a result waits and stall once the stages are full.
// Reset clears counts, sum and valids; window 14, reciprocal 1198373.
// Delay line contents are undefined after reset and need no clearing pass.
// Depends on qsma_pkg, qsma_if, qsma_delay_line and the assertion macro header.
`include "qstick_moving_average_assert.svh"

module qstick_moving_average (
	input  logic                                  clk,
	input  logic                                  arst_n,
	qsma_in_if.sink                               in_ch,
	qsma_out_if.source                            out_ch,
	input  logic                                  cfg_we,
	input  logic [qsma_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [qsma_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

	logic [qsma_pkg::CNT_BITS-1:0] win_q;
	logic [qsma_pkg::CNT_BITS-1:0] win_wr;
	logic [qsma_pkg::RECIP_BITS-1:0] recip_q;
	logic [qsma_pkg::CNT_BITS-1:0] fill_q;
	logic [qsma_pkg::CNT_BITS-1:0] fill_base;
	logic [qsma_pkg::CNT_BITS-1:0] fill_next;
	logic sub;
	logic emit;

	logic in_acc;
	logic adv_s1;
	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;
	logic rdy_s4;

	logic [qsma_pkg::DIFF_BITS-1:0] diff;
	logic [qsma_pkg::DIFF_BITS-1:0] tap;
	qsma_pkg::chain_ctrl_t chain_ctrl;

	logic valid_s1;
	logic clear_s1;
	logic emit_s1;
	logic [qsma_pkg::DIFF_BITS-1:0] diff_s1;
	logic [qsma_pkg::DIFF_BITS-1:0] oldest_s1;

	logic signed [qsma_pkg::SUM_BITS-1:0] sum_q;
	logic signed [qsma_pkg::SUM_BITS-1:0] sum_base;
	logic signed [qsma_pkg::SUM_BITS-1:0] sum_next;

	logic valid_s2;
	logic signed [qsma_pkg::SUM_BITS-1:0] sum_s2;
	logic signed [qsma_pkg::EXT_BITS-1:0] sum_ext;
	logic signed [qsma_pkg::HI_BITS-1:0] hi;
	logic [qsma_pkg::FRAC_BITS-1:0] lo;
	logic signed [qsma_pkg::RECIP_BITS:0] recip_s;
	logic [qsma_pkg::FRAC_BITS+qsma_pkg::RECIP_BITS-1:0] prod_lo;

	logic valid_s3;
	logic signed [qsma_pkg::PROD_HI_BITS-1:0] prod_hi_s3;
	logic [qsma_pkg::RECIP_BITS-1:0] lo_term_s3;
	logic signed [qsma_pkg::RES_BITS-1:0] res;
	logic [qsma_pkg::OUT_BITS-1:0] sat;

	logic valid_s4;
	logic [qsma_pkg::OUT_BITS-1:0] mean_s4;

	assign rdy_s4 = !valid_s4 || out_ch.ready;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;
	assign in_ch.ready = rdy_s1;
	assign in_acc = in_ch.valid && rdy_s1;
	assign adv_s1 = valid_s1 && rdy_s2;

	assign out_ch.valid = valid_s4;
	assign out_ch.mean_body = $signed(mean_s4);

	assign win_wr = qsma_pkg::clamp_window(cfg_wdata[qsma_pkg::LEN_BITS-1:0]);

	always_comb begin
		chain_ctrl.shift = in_acc;
		chain_ctrl.sel_load = cfg_we &&
			(qsma_pkg::cfg_reg_t'(cfg_index) == qsma_pkg::REG_WINDOW_LENGTH);
	end

	assign diff = qsma_pkg::DIFF_BITS'(in_ch.close_price) -
		qsma_pkg::DIFF_BITS'(in_ch.open_price);

	// Series bookkeeping for the incoming beat.
	always_comb begin
		fill_base = in_ch.start_new ? '0 : fill_q;
		sub = (fill_base >= win_q);
		fill_next = sub ? win_q : qsma_pkg::CNT_BITS'(fill_base + 1'b1);
		emit = (fill_next >= win_q);
	end

	qsma_delay_line u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (chain_ctrl),
		.win_load (win_wr),
		.diff_in  (diff),
		.tap      (tap)
	);

	always_comb begin
		sum_base = clear_s1 ? '0 : sum_q;
		sum_next = sum_base + qsma_pkg::SUM_BITS'($signed(diff_s1)) -
			qsma_pkg::SUM_BITS'($signed(oldest_s1));
	end

	// The sum splits into a floored high part and a fraction so that each
	// partial product stays narrow.
	always_comb begin
		sum_ext = qsma_pkg::EXT_BITS'(sum_s2);
		hi = sum_ext[qsma_pkg::EXT_BITS-1:qsma_pkg::FRAC_BITS];
		lo = sum_ext[qsma_pkg::FRAC_BITS-1:0];
		recip_s = {1'b0, recip_q};
		prod_lo = {{qsma_pkg::RECIP_BITS{1'b0}}, lo} * {{qsma_pkg::FRAC_BITS{1'b0}}, recip_q};
	end

	always_comb begin
		res = qsma_pkg::RES_BITS'(prod_hi_s3) + qsma_pkg::RES_BITS'(lo_term_s3);
		if ((&res[qsma_pkg::RES_BITS-1:qsma_pkg::OUT_BITS-1]) ||
			!(|res[qsma_pkg::RES_BITS-1:qsma_pkg::OUT_BITS-1])) begin
			sat = res[qsma_pkg::OUT_BITS-1:0];
		end else begin
			sat = {res[qsma_pkg::RES_BITS-1], {(qsma_pkg::OUT_BITS-1){~res[qsma_pkg::RES_BITS-1]}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= qsma_pkg::clamp_window(qsma_pkg::RESET_WINDOW_LENGTH);
			recip_q <= qsma_pkg::RESET_WINDOW_RECIPROCAL;
			fill_q <= '0;
			sum_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (qsma_pkg::cfg_reg_t'(cfg_index))
					qsma_pkg::REG_WINDOW_LENGTH: begin
						win_q <= win_wr;
					end
					qsma_pkg::REG_WINDOW_RECIPROCAL: begin
						recip_q <= cfg_wdata[qsma_pkg::RECIP_BITS-1:0];
					end
				endcase
			end
			if (in_acc) begin
				fill_q <= fill_next;
			end
			if (adv_s1) begin
				sum_q <= sum_next;
			end
			if (rdy_s1) begin
				valid_s1 <= in_ch.valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1 && emit_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			diff_s1 <= diff;
			oldest_s1 <= sub ? tap : '0;
			clear_s1 <= in_ch.start_new;
			emit_s1 <= emit;
		end
		if (rdy_s2) begin
			sum_s2 <= sum_next;
		end
		if (rdy_s3) begin
			prod_hi_s3 <= qsma_pkg::PROD_HI_BITS'(hi) * qsma_pkg::PROD_HI_BITS'(recip_s);
			lo_term_s3 <= prod_lo[qsma_pkg::FRAC_BITS+qsma_pkg::RECIP_BITS-1:qsma_pkg::FRAC_BITS];
		end
		if (rdy_s4) begin
			mean_s4 <= sat;
		end
	end

	`QSMA_ASSERT_NXT(a_fill_after_beat, clk, arst_n, in_acc, fill_q != '0)
	`QSMA_ASSERT_NXT(a_new_series_fill, clk, arst_n, in_acc && in_ch.start_new, fill_q == qsma_pkg::CNT_BITS'(1))
	`QSMA_ASSERT_IMP(a_clear_no_sub, clk, arst_n, valid_s1 && clear_s1, oldest_s1 == '0)

endmodule

// ===== tb/tb_qstick_moving_average.sv =====
`timescale 1ns / 1ps
// Self-checking bench for qstick_moving_average: drives candle beats and register writes,
// predicts every windowed mean body and compares it with the output channel.
// Depends on qsma_pkg, qsma_if and the block itself.
module tb_qstick_moving_average;

	localparam longint MEAN_MAX = (64'sd1 <<< (qsma_pkg::OUT_BITS - 1)) - 1;
	localparam longint MEAN_MIN = -MEAN_MAX - 1;
	localparam int RANDOM_ITEMS = 1700;
	localparam int STALL_CYCLES = 300;

	class body_mean_predictor;
		longint diff_hist[qsma_pkg::MAX_WINDOW];
		int unsigned wr_ptr;
		int unsigned fill;
		longint body_sum;
		logic [qsma_pkg::LEN_BITS-1:0] win_len;
		logic [qsma_pkg::RECIP_BITS-1:0] recip;
		logic signed [qsma_pkg::OUT_BITS-1:0] pending_means[$];
		int errors;
		int candles;
		int means;

		function new();
			wr_ptr = 0;
			fill = 0;
			body_sum = 0;
			win_len = qsma_pkg::RESET_WINDOW_LENGTH;
			recip = qsma_pkg::RESET_WINDOW_RECIPROCAL;
			errors = 0;
			candles = 0;
			means = 0;
		endfunction

		function void set_reg(qsma_pkg::cfg_reg_t idx, int unsigned val);
			if (idx == qsma_pkg::REG_WINDOW_LENGTH) begin
				win_len = qsma_pkg::LEN_BITS'(val);
			end else begin
				recip = qsma_pkg::RECIP_BITS'(val);
			end
		endfunction

		function int unsigned window_in_use();
			if (win_len == 0) begin
				return 1;
			end
			if (win_len > qsma_pkg::MAX_WINDOW) begin
				return qsma_pkg::MAX_WINDOW;
			end
			return win_len;
		endfunction

		function void note_candle(logic signed [qsma_pkg::PRICE_BITS-1:0] open_p,
				logic signed [qsma_pkg::PRICE_BITS-1:0] close_p, logic fresh);
			int unsigned w;
			longint diff;
			longint mean;
			logic signed [67:0] prod;
			w = window_in_use();
			diff = longint'(close_p) - longint'(open_p);
			candles++;
			if (fresh) begin
				fill = 0;
				body_sum = 0;
			end
			body_sum += diff;
			if (fill >= w) begin
				body_sum -= diff_hist[(wr_ptr + qsma_pkg::MAX_WINDOW - w) % qsma_pkg::MAX_WINDOW];
				fill = w;
			end else begin
				fill++;
			end
			diff_hist[wr_ptr] = diff;
			wr_ptr = (wr_ptr + 1) % qsma_pkg::MAX_WINDOW;
			if (fill < w) begin
				return;
			end
			prod = 68'(body_sum) * $signed(68'(recip));
			mean = longint'(prod >>> qsma_pkg::FRAC_BITS);
			if (mean > MEAN_MAX) begin
				mean = MEAN_MAX;
			end
			if (mean < MEAN_MIN) begin
				mean = MEAN_MIN;
			end
			pending_means.push_back(qsma_pkg::OUT_BITS'(mean));
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30) begin
				$display("[%0t] error: %s", $realtime, msg);
			end
		endtask

		task check_mean(logic signed [qsma_pkg::OUT_BITS-1:0] got);
			logic signed [qsma_pkg::OUT_BITS-1:0] want;
			means++;
			if (pending_means.size() == 0) begin
				report($sformatf("mean beat %0d arrived with nothing expected", got));
			end else begin
				want = pending_means.pop_front();
				if (got !== want) begin
					report($sformatf("mean_body got %0d expected %0d", got, want));
				end
			end
		endtask

		function int pending();
			return pending_means.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [qsma_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [qsma_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

	qsma_in_if in_ch();
	qsma_out_if out_ch();

	qstick_moving_average uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	body_mean_predictor sb = new();
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit stall_request = 0;
	int random_items = 0;
	int settings = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#5_000_000;
		$display("timeout: handshakes stopped moving");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else if (stall_request) begin
				stall_request = 0;
				hold_left = STALL_CYCLES;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check_mean(out_ch.mean_body);
		end
	end

	task automatic send_candle(logic signed [qsma_pkg::PRICE_BITS-1:0] open_p,
			logic signed [qsma_pkg::PRICE_BITS-1:0] close_p, logic fresh);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.open_price = open_p;
		in_ch.close_price = close_p;
		in_ch.start_new = fresh;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		sb.note_candle(open_p, close_p, fresh);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid = 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(qsma_pkg::cfg_reg_t idx, int unsigned val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = qsma_pkg::CFG_DATA_BITS'(val);
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, val);
		settings++;
	endtask

	function automatic logic signed [qsma_pkg::PRICE_BITS-1:0] pick_price(bit wide);
		if (wide) begin
			return qsma_pkg::PRICE_BITS'($urandom);
		end
		return qsma_pkg::PRICE_BITS'(int'($urandom_range(0, (1 << 21) - 1)) - (1 << 20));
	endfunction

	function automatic int unsigned matching_recip(int unsigned w);
		return ((1 << qsma_pkg::FRAC_BITS) + w / 2) / w;
	endfunction

	localparam logic signed [qsma_pkg::PRICE_BITS-1:0] P_MAX =
		{1'b0, {(qsma_pkg::PRICE_BITS-1){1'b1}}};
	localparam logic signed [qsma_pkg::PRICE_BITS-1:0] P_MIN =
		{1'b1, {(qsma_pkg::PRICE_BITS-1){1'b0}}};

	initial begin
		int unsigned w_raw;
		int unsigned w_eff;
		int unsigned n;
		int phase;
		bit wide;
		bit fresh;
		bit prev_narrow_fresh;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.open_price = '0;
		in_ch.close_price = '0;
		in_ch.start_new = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Window of one with unit reciprocal passes each body straight through.
		write_reg(qsma_pkg::REG_WINDOW_LENGTH, 1);
		write_reg(qsma_pkg::REG_WINDOW_RECIPROCAL, 1 << qsma_pkg::FRAC_BITS);
		send_idle_pct = 34;
		recv_idle_pct = 56;
		send_candle(0, 0, 1'b1);
		send_candle(P_MIN, P_MAX, 1'b0);
		send_candle(P_MAX, P_MIN, 1'b0);
		send_candle(-1, 0, 1'b0);
		send_candle(0, -1, 1'b0);
		send_candle(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		send_candle(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		send_candle(P_MAX, P_MAX, 1'b0);
		send_candle(P_MIN, P_MIN, 1'b0);
		wait_drained();

		// Zero length acts as one; an oversized reciprocal drives both saturation limits.
		write_reg(qsma_pkg::REG_WINDOW_LENGTH, 0);
		write_reg(qsma_pkg::REG_WINDOW_RECIPROCAL, (1 << qsma_pkg::RECIP_BITS) - 1);
		send_candle(P_MIN, P_MAX, 1'b1);
		send_candle(P_MAX, P_MIN, 1'b0);
		send_candle(0, 5, 1'b0);
		wait_drained();

		write_reg(qsma_pkg::REG_WINDOW_LENGTH, 2);
		write_reg(qsma_pkg::REG_WINDOW_RECIPROCAL, 0);
		send_candle(P_MIN, P_MAX, 1'b1);
		send_candle(-7, 100, 1'b0);
		send_candle(P_MAX, P_MIN, 1'b0);
		wait_drained();

		// A new series in the middle of warm-up restarts the count.
		write_reg(qsma_pkg::REG_WINDOW_LENGTH, 3);
		write_reg(qsma_pkg::REG_WINDOW_RECIPROCAL, matching_recip(3));
		send_candle(10, 40, 1'b1);
		send_candle(-300, 20, 1'b0);
		send_candle(5, -9, 1'b1);
		send_candle(1000, 999, 1'b0);
		send_candle(-2, 77, 1'b0);
		send_candle(P_MIN, P_MIN + 3, 1'b0);
		wait_drained();

		phase = 0;
		prev_narrow_fresh = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 34;
				recv_idle_pct = 56;
			end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 56;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase == 0) begin
				w_raw = 2;
			end else begin
				case ($urandom_range(19))
					0: w_raw = 0;
					1: w_raw = qsma_pkg::MAX_WINDOW;
					2: w_raw = $urandom_range(qsma_pkg::MAX_WINDOW + 1,
						(1 << qsma_pkg::LEN_BITS) - 1);
					3: w_raw = qsma_pkg::MAX_WINDOW - 1;
					4, 5: w_raw = $urandom_range(17, 64);
					default: w_raw = $urandom_range(1, 16);
				endcase
			end
			write_reg(qsma_pkg::REG_WINDOW_LENGTH, w_raw);
			w_eff = sb.window_in_use();
			case ($urandom_range(9))
				0: write_reg(qsma_pkg::REG_WINDOW_RECIPROCAL, 0);
				1: write_reg(qsma_pkg::REG_WINDOW_RECIPROCAL, (1 << qsma_pkg::RECIP_BITS) - 1);
				2: write_reg(qsma_pkg::REG_WINDOW_RECIPROCAL,
					$urandom_range(0, (1 << qsma_pkg::RECIP_BITS) - 1));
				default: write_reg(qsma_pkg::REG_WINDOW_RECIPROCAL, matching_recip(w_eff));
			endcase
			// A series may carry over a window change only when its running sum
			// cannot outgrow the hardware accumulator.
			if (phase == 1) begin
				fresh = 0;
			end else begin
				fresh = !(prev_narrow_fresh && $urandom_range(2) == 0);
			end
			wide = (phase == 0 || !fresh) ? 1'b0 : ($urandom_range(2) == 0);
			prev_narrow_fresh = fresh && !wide;
			n = w_eff + $urandom_range(4, 40);
			if (phase == 0) begin
				n = 80;
				stall_request = 1;
			end
			for (int i = 0; i < n; i++) begin
				send_candle(pick_price(wide), pick_price(wide),
					(i == 0) ? fresh : ($urandom_range(59) == 0));
				random_items++;
			end
			wait_drained();
			phase++;
		end

		repeat (10) @(negedge clk);
		while (sb.pending() != 0) begin
			sb.report($sformatf("mean %0d never arrived", sb.pending_means.pop_front()));
		end
		$display("Run covered %0d candle beats and %0d mean beats across %0d register writes,",
			sb.candles, sb.means, settings);
		$display("windows from zero past the line depth, reciprocals from zero to full scale.");
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
